@@ design/max_heap_priority_queue_top_defines.svh @@
// Assertion macros shared by the priority queue RTL
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH

// checked while out of reset
`define MHPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define MHPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ design/mhpq_pkg.sv @@
// Types and codes of the max-heap priority queue
`default_nettype none
package mhpq_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned OpW    = 3;
  localparam int unsigned StW    = 3;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned CountW = 7;

  typedef enum logic [OpW-1:0] {
    OP_APPEND  = 3'd0,
    OP_BUILD   = 3'd1,
    OP_INSERT  = 3'd2,
    OP_EXTRACT = 3'd3,
    OP_INCR    = 3'd4
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_SMALLER   = 3'd2,
    ST_FULL      = 3'd3,
    ST_RANGE     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_INC_CMP,
    S_LD,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_FIN
  } state_e;

  localparam logic signed [KeyW-1:0] KeyNone = -32'sd1;

endpackage
`default_nettype wire

@@ design/mhpq_in_if.sv @@
// Operation channel of the priority queue
`default_nettype none
interface mhpq_in_if;
  logic                               valid;
  logic                               ready;
  logic [mhpq_pkg::OpW-1:0]           op;
  logic signed [mhpq_pkg::KeyW-1:0]   key;
  logic [mhpq_pkg::IdxW-1:0]          index;

  modport source (output valid, op, key, index, input ready);
  modport sink (input valid, op, key, index, output ready);
endinterface
`default_nettype wire

@@ design/mhpq_out_if.sv @@
// Result channel of the priority queue
`default_nettype none
interface mhpq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mhpq_pkg::KeyW-1:0]   value;
  logic [mhpq_pkg::StW-1:0]           status;
  logic [mhpq_pkg::CountW-1:0]        count;
  logic signed [mhpq_pkg::KeyW-1:0]   top;

  modport source (output valid, value, status, count, top, input ready);
  modport sink (input valid, value, status, count, top, output ready);
endinterface
`default_nettype wire

@@ design/mhpq_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module mhpq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

@@ design/max_heap_priority_queue_top.sv @@
// Top level of the max-heap priority queue
//
// channel | dir | handshake   | payload
// in_i    | in  | valid/ready | op, key, index
// out_o   | out | valid/ready | value, status, count, top
//
// One operation at a time; in_i.ready is high only while the sequencer is idle.
// Append and rejected operations go straight to S_FIN; sift-up passes through
// S_UP_RD, S_UP_CMP a level, sift-down S_DN_RDL, S_DN_RDR, S_DN_CMP a level, both
// set by the single read port of the heap RAM. Build sifts down each inner node.
// Reset empties the queue at once; RAM contents stay undefined until written.
// A finished result waits in the output register; the next operation is taken
// while it waits, and only its own result stalls behind it.
`default_nettype none
`include "max_heap_priority_queue_top_defines.svh"
module max_heap_priority_queue_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mhpq_in_if.sink    in_i,
  mhpq_out_if.source out_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = AW + 2;
  localparam int unsigned MW = CW + mhpq_pkg::IdxW;
  localparam int unsigned KW = mhpq_pkg::KeyW;

  mhpq_pkg::state_e          state_q, state_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [AW-1:0]             pos_q, pos_d;
  logic [AW-1:0]             bi_q, bi_d;
  logic                      bld_q, bld_d;
  logic signed [KW-1:0]      cur_q, cur_d;
  logic signed [KW-1:0]      lval_q, lval_d;
  logic signed [KW-1:0]      top_q, top_d;
  logic signed [KW-1:0]      val_q, val_d;
  mhpq_pkg::status_e         st_q, st_d;

  logic                      ov_q, ov_d;
  logic signed [KW-1:0]      ovalue_q, ovalue_d;
  logic [mhpq_pkg::StW-1:0]  ostat_q, ostat_d;
  logic [mhpq_pkg::CountW-1:0] ocnt_q, ocnt_d;
  logic signed [KW-1:0]      otop_q, otop_d;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic signed [KW-1:0]      ram_wdata, rdata;

  logic                      accept, full, empty, idx_ok, l_ok, r_ok, big_r, swap_dn;
  logic                      out_free, dn_more, up_go;
  logic [EW-1:0]             l_e, r_e, cnt_e;
  logic [AW-1:0]             parent, b_pos, bi_first;
  logic signed [KW-1:0]      b_val;
  mhpq_pkg::op_e             op;

  mhpq_ram #(.Width(KW), .Depth(CAPACITY)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  assign op       = mhpq_pkg::op_e'(in_i.op);
  assign in_i.ready = (state_q == mhpq_pkg::S_IDLE);
  assign accept   = in_i.valid && in_i.ready;
  assign full     = (cnt_q == CW'(CAPACITY));
  assign empty    = (cnt_q == '0);
  assign idx_ok   = MW'(in_i.index) < MW'(cnt_q);
  assign cnt_e    = EW'(cnt_q);
  assign l_e      = {1'b0, pos_q, 1'b1};
  assign r_e      = l_e + EW'(1);
  assign l_ok     = l_e < cnt_e;
  assign r_ok     = r_e < cnt_e;
  assign parent   = AW'((pos_q - AW'(1)) >> 1);
  assign big_r    = r_ok && (rdata > lval_q);
  assign b_val    = big_r ? rdata : lval_q;
  assign b_pos    = big_r ? AW'(r_e) : AW'(l_e);
  assign swap_dn  = b_val > cur_q;
  assign bi_first = AW'((cnt_q >> 1) - CW'(1));
  assign dn_more  = bld_q && (bi_q != '0);
  assign up_go    = rdata < cur_q;
  assign out_free = !ov_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mhpq_pkg::S_IDLE: begin
        if (accept) begin
          state_d = mhpq_pkg::S_FIN;
          case (op)
            mhpq_pkg::OP_INSERT:  if (!full) state_d = mhpq_pkg::S_UP_RD;
            mhpq_pkg::OP_INCR:    if (idx_ok) state_d = mhpq_pkg::S_INC_CMP;
            mhpq_pkg::OP_EXTRACT: if (cnt_q > CW'(1)) state_d = mhpq_pkg::S_LD;
            mhpq_pkg::OP_BUILD:   if (cnt_q > CW'(1)) state_d = mhpq_pkg::S_LD;
            default: ;
          endcase
        end
      end
      mhpq_pkg::S_UP_RD:   state_d = (pos_q == '0) ? mhpq_pkg::S_FIN : mhpq_pkg::S_UP_CMP;
      mhpq_pkg::S_UP_CMP:  state_d = up_go ? mhpq_pkg::S_UP_RD : mhpq_pkg::S_FIN;
      mhpq_pkg::S_INC_CMP: state_d = (cur_q < rdata) ? mhpq_pkg::S_FIN : mhpq_pkg::S_UP_RD;
      mhpq_pkg::S_LD:      state_d = mhpq_pkg::S_DN_RDL;
      mhpq_pkg::S_DN_RDL: begin
        if (l_ok) begin
          state_d = mhpq_pkg::S_DN_RDR;
        end else begin
          state_d = dn_more ? mhpq_pkg::S_LD : mhpq_pkg::S_FIN;
        end
      end
      mhpq_pkg::S_DN_RDR:  state_d = mhpq_pkg::S_DN_CMP;
      mhpq_pkg::S_DN_CMP: begin
        if (swap_dn) begin
          state_d = mhpq_pkg::S_DN_RDL;
        end else begin
          state_d = dn_more ? mhpq_pkg::S_LD : mhpq_pkg::S_FIN;
        end
      end
      mhpq_pkg::S_FIN:     if (out_free) state_d = mhpq_pkg::S_IDLE;
      default:             state_d = mhpq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    bi_d      = bi_q;
    bld_d     = bld_q;
    cur_d     = cur_q;
    lval_d    = lval_q;
    val_d     = val_q;
    st_d      = st_q;
    ov_d      = ov_q;
    ovalue_d  = ovalue_q;
    ostat_d   = ostat_q;
    ocnt_d    = ocnt_q;
    otop_d    = otop_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = cur_q;
    ram_raddr = pos_q;

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      mhpq_pkg::S_IDLE: begin
        if (accept) begin
          val_d = '0;
          st_d  = mhpq_pkg::ST_OK;
          cur_d = in_i.key;
          bld_d = 1'b0;
          case (op)
            mhpq_pkg::OP_APPEND: begin
              if (full) begin
                st_d = mhpq_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(cnt_q);
                ram_wdata = in_i.key;
                cnt_d     = cnt_q + CW'(1);
              end
            end
            mhpq_pkg::OP_INSERT: begin
              if (full) begin
                st_d = mhpq_pkg::ST_FULL;
              end else begin
                pos_d = AW'(cnt_q);
                cnt_d = cnt_q + CW'(1);
              end
            end
            mhpq_pkg::OP_EXTRACT: begin
              if (empty) begin
                st_d  = mhpq_pkg::ST_UNDERFLOW;
                val_d = mhpq_pkg::KeyNone;
              end else begin
                val_d     = top_q;
                cnt_d     = cnt_q - CW'(1);
                pos_d     = '0;
                ram_raddr = AW'(cnt_q - CW'(1));
              end
            end
            mhpq_pkg::OP_BUILD: begin
              bld_d     = 1'b1;
              bi_d      = bi_first;
              pos_d     = bi_first;
              ram_raddr = bi_first;
            end
            mhpq_pkg::OP_INCR: begin
              if (!idx_ok) begin
                st_d = mhpq_pkg::ST_RANGE;
              end else begin
                pos_d     = AW'(in_i.index);
                ram_raddr = AW'(in_i.index);
              end
            end
            default: ;
          endcase
        end
      end
      mhpq_pkg::S_UP_RD: begin
        if (pos_q == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_raddr = parent;
        end
      end
      mhpq_pkg::S_UP_CMP: begin
        ram_we = 1'b1;
        if (up_go) begin
          ram_wdata = rdata;
          pos_d     = parent;
        end
      end
      mhpq_pkg::S_INC_CMP: begin
        if (cur_q < rdata) begin
          st_d = mhpq_pkg::ST_SMALLER;
        end
      end
      mhpq_pkg::S_LD: begin
        cur_d = rdata;
      end
      mhpq_pkg::S_DN_RDL: begin
        if (l_ok) begin
          ram_raddr = AW'(l_e);
        end else begin
          ram_we = 1'b1;
          if (dn_more) begin
            bi_d      = bi_q - AW'(1);
            pos_d     = bi_q - AW'(1);
            ram_raddr = bi_q - AW'(1);
          end
        end
      end
      mhpq_pkg::S_DN_RDR: begin
        lval_d    = rdata;
        ram_raddr = AW'(r_e);
      end
      mhpq_pkg::S_DN_CMP: begin
        ram_we = 1'b1;
        if (swap_dn) begin
          ram_wdata = b_val;
          pos_d     = b_pos;
        end else if (dn_more) begin
          bi_d      = bi_q - AW'(1);
          pos_d     = bi_q - AW'(1);
          ram_raddr = bi_q - AW'(1);
        end
      end
      mhpq_pkg::S_FIN: begin
        if (out_free) begin
          ov_d     = 1'b1;
          ovalue_d = val_q;
          ostat_d  = st_q;
          ocnt_d   = mhpq_pkg::CountW'(cnt_q);
          otop_d   = empty ? '0 : top_q;
        end
      end
      default: ;
    endcase
  end

  assign top_d = (ram_we && (ram_waddr == '0)) ? ram_wdata : top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhpq_pkg::S_IDLE;
      cnt_q   <= '0;
      bld_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bld_q   <= bld_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    bi_q     <= bi_d;
    cur_q    <= cur_d;
    lval_q   <= lval_d;
    top_q    <= top_d;
    val_q    <= val_d;
    st_q     <= st_d;
    ovalue_q <= ovalue_d;
    ostat_q  <= ostat_d;
    ocnt_q   <= ocnt_d;
    otop_q   <= otop_d;
  end

  assign out_o.valid  = ov_q;
  assign out_o.value  = ovalue_q;
  assign out_o.status = ostat_q;
  assign out_o.count  = ocnt_q;
  assign out_o.top    = otop_q;

  `MHPQ_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(CAPACITY), "entry count above capacity")
  `MHPQ_ASSERT(a_busy_after_take, accept |=> state_q != mhpq_pkg::S_IDLE, "operation lost")
  `MHPQ_ASSERT(a_wr_in_range, (ram_we && state_q != mhpq_pkg::S_IDLE) |-> (CW'(ram_waddr) < cnt_q), "heap write beyond count")
  `MHPQ_ASSERT(a_underflow_val, (ov_q && ostat_q == mhpq_pkg::ST_UNDERFLOW) |-> (ovalue_q == mhpq_pkg::KeyNone), "underflow without minus one")

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the max-heap priority queue: directed and random operations scored against a heap model
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
    logic [6:0]         count;
    logic signed [31:0] top;
  } heap_result_t;

  class heap_scoreboard;
    logic signed [31:0] keys[64];
    int unsigned        n_keys;
    heap_result_t       pending[$];
    int                 errors;
    int                 n_checked;

    function void swap_keys(int unsigned a, int unsigned b);
      logic signed [31:0] t;
      t = keys[a];
      keys[a] = keys[b];
      keys[b] = t;
    endfunction

    function void sink_key(int unsigned pos);
      int unsigned l, r, big;
      forever begin
        l = 2 * pos + 1;
        r = l + 1;
        big = pos;
        if (l < n_keys && keys[l] > keys[big]) big = l;
        if (r < n_keys && keys[r] > keys[big]) big = r;
        if (big == pos) return;
        swap_keys(pos, big);
        pos = big;
      end
    endfunction

    function void raise_key(int unsigned pos);
      int unsigned up;
      while (pos > 0) begin
        up = (pos - 1) / 2;
        if (!(keys[up] < keys[pos])) return;
        swap_keys(pos, up);
        pos = up;
      end
    endfunction

    function void note_op(logic [2:0] op, logic signed [31:0] key, logic [5:0] idx);
      heap_result_t res;
      int unsigned  i;
      res = '0;
      res.status = mhpq_pkg::ST_OK;
      case (op)
        mhpq_pkg::OP_APPEND, mhpq_pkg::OP_INSERT: begin
          if (n_keys >= 64) begin
            res.status = mhpq_pkg::ST_FULL;
          end else begin
            keys[n_keys] = key;
            n_keys++;
            if (op == mhpq_pkg::OP_INSERT) raise_key(n_keys - 1);
          end
        end
        mhpq_pkg::OP_BUILD: begin
          i = n_keys / 2;
          while (i > 0) begin
            i--;
            sink_key(i);
          end
        end
        mhpq_pkg::OP_EXTRACT: begin
          if (n_keys == 0) begin
            res.value = mhpq_pkg::KeyNone;
            res.status = mhpq_pkg::ST_UNDERFLOW;
          end else begin
            res.value = keys[0];
            keys[0] = keys[n_keys - 1];
            n_keys--;
            sink_key(0);
          end
        end
        mhpq_pkg::OP_INCR: begin
          if (idx >= n_keys) res.status = mhpq_pkg::ST_RANGE;
          else if (key < keys[idx]) res.status = mhpq_pkg::ST_SMALLER;
          else begin
            keys[idx] = key;
            raise_key(idx);
          end
        end
        default: ;
      endcase
      res.count = n_keys[6:0];
      res.top = (n_keys != 0) ? keys[0] : '0;
      pending.push_back(res);
    endfunction

    function void check_result(heap_result_t got);
      heap_result_t exp;
      n_checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.value !== exp.value) begin
        $display("%0t: value exp %0d got %0d", $time, exp.value, got.value);
        errors++;
      end
      if (got.status !== exp.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.count !== exp.count) begin
        $display("%0t: count exp %0d got %0d", $time, exp.count, got.count);
        errors++;
      end
      if (got.top !== exp.top) begin
        $display("%0t: top exp %0d got %0d", $time, exp.top, got.top);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  mhpq_in_if  op_ch ();
  mhpq_out_if res_ch ();

  max_heap_priority_queue_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (op_ch.sink),
    .out_o (res_ch.source)
  );

  heap_scoreboard sb;
  int unsigned    cycles;
  int unsigned    n_sent;
  bit             no_idle;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // drain the result channel with random stalls
  initial begin
    int unsigned gap;
    res_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_ch.valid) @(posedge clk_i);
      sb.check_result({res_ch.value, res_ch.status, res_ch.count, res_ch.top});
    end
  end

  task automatic send_op(logic [2:0] op, logic signed [31:0] key, logic [5:0] idx);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      op_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    op_ch.valid <= 1'b1;
    op_ch.op    <= op;
    op_ch.key   <= key;
    op_ch.index <= idx;
    @(posedge clk_i);
    while (!op_ch.ready) @(posedge clk_i);
    sb.note_op(op, key, idx);
    n_sent++;
  endtask

  function automatic logic signed [31:0] rand_key();
    case ($urandom_range(0, 3))
      0: return $signed($urandom());
      1: return $signed($urandom_range(0, 40)) - 20;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 1000));
    endcase
  endfunction

  task automatic random_op();
    int unsigned        r;
    logic signed [31:0] k;
    logic [5:0]         i;
    r = $urandom_range(0, 99);
    k = rand_key();
    i = (sb.n_keys > 0 && $urandom_range(0, 4) != 0) ?
        6'($urandom_range(0, sb.n_keys - 1)) : 6'($urandom());
    if (r < 15) send_op(mhpq_pkg::OP_APPEND, k, i);
    else if (r < 22) send_op(mhpq_pkg::OP_BUILD, k, i);
    else if (r < 52) send_op(mhpq_pkg::OP_INSERT, k, i);
    else if (r < 80) send_op(mhpq_pkg::OP_EXTRACT, k, i);
    else if (r < 97) begin
      if (sb.n_keys > 0 && i < sb.n_keys && $urandom_range(0, 3) != 0)
        k = sb.keys[i] + $signed(32'($urandom_range(0, 50)));
      if (k < sb.keys[i] && $urandom_range(0, 1) == 1 && i < sb.n_keys) k = sb.keys[i];
      send_op(mhpq_pkg::OP_INCR, k, i);
    end else send_op(3'($urandom_range(5, 7)), k, i);
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    op_ch.valid = 1'b0;
    op_ch.op = mhpq_pkg::OP_APPEND;
    op_ch.key = '0;
    op_ch.index = '0;
    cycles = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: underflow, range, extremes, build, unused codes
    send_op(mhpq_pkg::OP_EXTRACT, 32'sd0, 6'd0);
    send_op(mhpq_pkg::OP_INCR, 32'sd5, 6'd63);
    send_op(mhpq_pkg::OP_BUILD, 32'sd0, 6'd0);
    send_op(mhpq_pkg::OP_APPEND, 32'sh80000000, 6'd0);
    send_op(mhpq_pkg::OP_BUILD, 32'sd0, 6'd0);
    send_op(mhpq_pkg::OP_APPEND, 32'sd3, 6'd0);
    send_op(mhpq_pkg::OP_APPEND, 32'sh7fffffff, 6'd0);
    send_op(mhpq_pkg::OP_APPEND, -32'sd1, 6'd0);
    send_op(mhpq_pkg::OP_BUILD, 32'sd0, 6'd0);
    send_op(mhpq_pkg::OP_INSERT, 32'sd100, 6'd0);
    send_op(mhpq_pkg::OP_INCR, -32'sd5, 6'd3);
    send_op(mhpq_pkg::OP_INCR, 32'sh7fffffff, 6'd3);
    send_op(mhpq_pkg::OP_INCR, 32'sh80000000, 6'd1);
    send_op(3'd5, 32'sd1, 6'd1);
    send_op(3'd6, 32'sd1, 6'd1);
    send_op(3'd7, 32'sd1, 6'd1);
    repeat (6) send_op(mhpq_pkg::OP_EXTRACT, 32'sd0, 6'd0);

    // fill to capacity, overflow both ways, then drain
    no_idle = 1'b1;
    for (int k = 0; k < 64; k++) send_op(mhpq_pkg::OP_APPEND, rand_key(), 6'($urandom()));
    send_op(mhpq_pkg::OP_APPEND, 32'sd1, 6'd0);
    send_op(mhpq_pkg::OP_INSERT, 32'sd1, 6'd0);
    send_op(mhpq_pkg::OP_BUILD, 32'sd0, 6'd0);
    send_op(mhpq_pkg::OP_INCR, 32'sh7fffffff, 6'd63);
    no_idle = 1'b0;
    for (int k = 0; k < 66; k++) send_op(mhpq_pkg::OP_EXTRACT, 32'sd0, 6'd0);

    for (int k = 0; k < 700; k++) begin
      if (k % 200 == 100) no_idle = 1'b1;
      if (k % 200 == 150) no_idle = 1'b0;
      random_op();
    end
    op_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("Sent %0d operations, checked %0d results incl. full, empty and range cases.",
             n_sent, sb.n_checked);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
